FILE: hdl/ipt_pkg.sv
// Shared types and constants for the inverted page table translate unit.
// No dependencies; used by ipt_div, the top level, the checker and the testbench.
package ipt_pkg;

  localparam int ADDR_W  = 24;   // logical line address
  localparam int LPF_W   = 11;   // lines per frame register
  localparam int PID_W   = 16;
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 8;    // frame number / found frame fields
  localparam int LINE_W  = 18;   // physical line field
  localparam int DCNT_W  = 5;    // divider step counter, holds ADDR_W

  localparam logic [LPF_W-1:0] LPF_RESET = 11'd16;

  // request kinds carried on in_tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  // divider result
  typedef struct packed {
    logic [ADDR_W-1:0] quo;
    logic [LPF_W-1:0]  rem;
  } div_res_t;

endpackage

FILE: hdl/ipt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ipt_div.sv
// Radix-2 restoring divider: address / lines per frame, one quotient bit per cycle.
// Depends on ipt_pkg.
module ipt_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ipt_pkg::ADDR_W-1:0]   dividend,
  input  logic [ipt_pkg::LPF_W-1:0]    divisor,   // never zero
  output logic                         done,      // one-cycle pulse
  output ipt_pkg::div_res_t            res
);

  logic [ipt_pkg::ADDR_W-1:0] quo_r;
  logic [ipt_pkg::LPF_W-1:0]  rem_r;
  logic [ipt_pkg::LPF_W-1:0]  dvs_r;
  logic [ipt_pkg::DCNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [ipt_pkg::LPF_W:0]    shifted;
  logic [ipt_pkg::LPF_W:0]    diff;
  logic                       qbit;

  always_comb begin
    shifted = {rem_r, quo_r[ipt_pkg::ADDR_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    qbit    = (shifted >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ipt_pkg::DCNT_W'(ipt_pkg::ADDR_W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[ipt_pkg::ADDR_W-2:0], qbit};
        rem_r <= qbit ? diff[ipt_pkg::LPF_W-1:0] : shifted[ipt_pkg::LPF_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ipt_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign res.quo = quo_r;
  assign res.rem = rem_r;

endmodule

FILE: hdl/inverted_page_table_translate_unit.sv
// Inverted page table translate unit: one owner entry {pid, page} per physical frame.
// Depends on ipt_pkg, ipt_ram and ipt_div.
//
// Flow: a write request goes to the output register; a translate request runs the divide,
//   then the table scan unless the page is too large (one entry read per cycle from the
//   RAM port), then the multiply on a hit, and then the output register.
// Throughput: one request at a time; next request taken as soon as the result
//   sits in the output register.
// Reset: synchronous, active low. After reset a clearing pass writes process 0,
//   page 0 to every frame, during which in_tready stays low.
//   lines_per_frame resets to 16.
module inverted_page_table_translate_unit #(
  parameter int FRAMES = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  // config: lines_per_frame
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,

  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,    // [0] func
  input  logic [63:0] in_tdata,    // [7:0] frame_number, [23:8] process_id,
                                   // [39:24] page_number, [63:40] logical_address

  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,   // [0] hit
  output logic [31:0] out_tdata    // [7:0] found_frame, [25:8] physical_line, rest 0
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;  // frame index
  localparam int CW = $clog2(FRAMES + 1);                 // scan counter, holds FRAMES
  localparam int EW = ipt_pkg::PID_W + ipt_pkg::PAGE_W;   // entry width
  localparam int PW = FW + ipt_pkg::LPF_W;                // frame * lpf product

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_MUL,
    ST_DONE
  } state_t;

  // request fields
  logic                        req_func;
  logic [ipt_pkg::FRAME_W-1:0] req_frame;
  logic [ipt_pkg::PID_W-1:0]   req_pid;
  logic [ipt_pkg::PAGE_W-1:0]  req_page;
  logic [ipt_pkg::ADDR_W-1:0]  req_addr;

  assign req_func  = in_tuser;
  assign req_frame = in_tdata[7:0];
  assign req_pid   = in_tdata[23:8];
  assign req_page  = in_tdata[39:24];
  assign req_addr  = in_tdata[63:40];

  // config register
  logic [ipt_pkg::LPF_W-1:0] lpf_r;
  logic [ipt_pkg::LPF_W-1:0] lpf_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpf_r <= ipt_pkg::LPF_RESET;
    end else if (cfg_we) begin
      lpf_r <= cfg_wdata;
    end
  end

  // zero lines per frame behaves as one
  assign lpf_eff = (lpf_r == '0) ? ipt_pkg::LPF_W'(1) : lpf_r;

  state_t                      state_r;
  logic [CW-1:0]               scan_idx_r;
  logic                        rd_valid_r;
  logic [FW-1:0]               rd_idx_r;
  logic [FW-1:0]               found_r;
  logic [ipt_pkg::PID_W-1:0]   pid_r;
  logic [ipt_pkg::PAGE_W-1:0]  page_r;
  logic [ipt_pkg::LPF_W-1:0]   off_r;
  logic [PW-1:0]               prod_r;
  logic                        hit_r;

  logic                        out_tvalid_r;
  logic                        out_hit_r;
  logic [ipt_pkg::FRAME_W-1:0] out_frame_r;
  logic [ipt_pkg::LINE_W-1:0]  out_line_r;

  logic in_acc;
  logic out_free;
  logic wr_req;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  // frames at or above FRAMES are ignored
  assign wr_req    = in_acc && (req_func == ipt_pkg::FUNC_WRITE) &&
                     (32'(req_frame) < FRAMES);

  // divider
  logic              div_start;
  logic              div_done;
  ipt_pkg::div_res_t div_res;

  assign div_start = in_acc && (req_func == ipt_pkg::FUNC_XLATE);

  ipt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (req_addr),
    .divisor  (lpf_eff),
    .done     (div_done),
    .res      (div_res)
  );

  // owner table: {pid, page} per frame
  logic          ram_we;
  logic [FW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic          match;
  logic          last_rd;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = scan_idx_r[FW-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = wr_req;
      ram_waddr = FW'(req_frame);
      ram_wdata = {req_pid, req_page};
    end
  end

  ipt_ram #(
    .WIDTH (EW),
    .DEPTH (FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r[FW-1:0]),
    .rdata (ram_rdata)
  );

  assign match   = rd_valid_r && (ram_rdata == {pid_r, page_r});
  assign last_rd = rd_valid_r && (rd_idx_r == FW'(FRAMES - 1));

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      scan_idx_r   <= '0;
      rd_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // ST_DONE handles the output register itself
      if (out_tvalid_r && out_tready && state_r != ST_DONE) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          scan_idx_r <= scan_idx_r + 1'b1;
          if (scan_idx_r[FW-1:0] == FW'(FRAMES - 1)) begin
            state_r <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            pid_r <= req_pid;
            hit_r <= 1'b0;
            if (req_func == ipt_pkg::FUNC_WRITE) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          if (div_done) begin
            page_r     <= div_res.quo[ipt_pkg::PAGE_W-1:0];
            off_r      <= div_res.rem;
            scan_idx_r <= '0;
            rd_valid_r <= 1'b0;
            // a page that does not fit 16 bits can never match
            if (div_res.quo[ipt_pkg::ADDR_W-1:ipt_pkg::PAGE_W] != '0) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          // read issued at scan_idx_r, compared in the next cycle at rd_idx_r
          rd_idx_r <= scan_idx_r[FW-1:0];
          if (scan_idx_r < CW'(FRAMES)) begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
          if (match) begin
            found_r    <= rd_idx_r;
            hit_r      <= 1'b1;
            rd_valid_r <= 1'b0;
            state_r    <= ST_MUL;
          end else if (last_rd) begin
            rd_valid_r <= 1'b0;
            state_r    <= ST_DONE;
          end else begin
            rd_valid_r <= (scan_idx_r < CW'(FRAMES));
          end
        end

        ST_MUL: begin
          prod_r  <= PW'(found_r) * PW'(lpf_eff);
          state_r <= ST_DONE;
        end

        ST_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_hit_r    <= hit_r;
            out_frame_r  <= hit_r ? ipt_pkg::FRAME_W'(found_r) : '0;
            out_line_r   <= hit_r ? ipt_pkg::LINE_W'(prod_r + PW'(off_r)) : '0;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {6'd0, out_line_r, out_frame_r};

  // checks
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("request taken while busy");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide phase");

  a_match_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && match) |=> (state_r == ST_MUL && hit_r))
    else $error("scan hit not followed by multiply");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_hit_r) |-> (out_frame_r == '0 && out_line_r == '0))
    else $error("miss result carries nonzero fields");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DIV) |-> !ram_we)
    else $error("table written during translation");

endmodule

FILE: test/ipt_translate_checker.sv
// Checker for the inverted page table translate unit: watches the request, result and
// config channels, predicts each result from its own table copy and compares.
// Depends on ipt_pkg.
`timescale 1ns / 100ps

module ipt_translate_checker #(
  parameter int FRAMES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        in_tuser,    // [0] func
  input  logic [63:0] in_tdata,    // [7:0] frame, [23:8] pid, [39:24] page, [63:40] addr
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        out_tuser,   // [0] hit
  input  logic [31:0] out_tdata,   // [7:0] found_frame, [25:8] physical_line
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic                        hit;
    logic [ipt_pkg::FRAME_W-1:0] frame;
    logic [ipt_pkg::LINE_W-1:0]  line;
  } xlate_result_t;

  logic [ipt_pkg::PID_W-1:0]  owner_pid  [FRAMES];
  logic [ipt_pkg::PAGE_W-1:0] owner_page [FRAMES];
  logic [ipt_pkg::LPF_W-1:0]  lines_per_frame;
  xlate_result_t              result_expect_q [$];
  int                         err_count = 0;

  assign errors = err_count;

  // first-match scan, lowest frame wins
  function automatic xlate_result_t predict_translate(
      input logic [ipt_pkg::PID_W-1:0]  pid,
      input logic [ipt_pkg::ADDR_W-1:0] addr);
    xlate_result_t r;
    int unsigned   divisor;
    int unsigned   page;
    int unsigned   offset;
    int unsigned   line;
    r = '0;
    divisor = (lines_per_frame == 0) ? 1 : lines_per_frame;  // zero acts as one
    page    = addr / divisor;
    offset  = addr % divisor;
    if (page <= 32'hFFFF) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (!r.hit && owner_pid[i] == pid &&
            owner_page[i] == page[ipt_pkg::PAGE_W-1:0]) begin
          line    = i * divisor + offset;
          r.hit   = 1'b1;
          r.frame = i[ipt_pkg::FRAME_W-1:0];
          r.line  = line[ipt_pkg::LINE_W-1:0];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    xlate_result_t               exp_r;
    xlate_result_t               got_r;
    logic [ipt_pkg::FRAME_W-1:0] req_frame;
    logic [ipt_pkg::PID_W-1:0]   req_pid;
    logic [ipt_pkg::PAGE_W-1:0]  req_page;
    logic [ipt_pkg::ADDR_W-1:0]  req_addr;
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        owner_pid[i]  = '0;
        owner_page[i] = '0;
      end
      lines_per_frame = ipt_pkg::LPF_RESET;
      result_expect_q.delete();
    end else begin
      if (cfg_we) lines_per_frame = cfg_wdata;
      if (in_tvalid && in_tready) begin
        req_frame = in_tdata[7:0];
        req_pid   = in_tdata[23:8];
        req_page  = in_tdata[39:24];
        req_addr  = in_tdata[63:40];
        exp_r     = '0;
        if (in_tuser == ipt_pkg::FUNC_WRITE) begin
          if (req_frame < FRAMES) begin
            owner_pid[req_frame]  = req_pid;
            owner_page[req_frame] = req_page;
          end
        end else begin
          exp_r = predict_translate(req_pid, req_addr);
        end
        result_expect_q.push_back(exp_r);
      end
      if (out_tvalid && out_tready) begin
        got_r.hit   = out_tuser;
        got_r.frame = out_tdata[7:0];
        got_r.line  = out_tdata[25:8];
        if (result_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected, got hit %0b frame %0d line %0d",
                   $time, got_r.hit, got_r.frame, got_r.line);
          err_count++;
        end else begin
          exp_r = result_expect_q.pop_front();
          if (got_r.hit !== exp_r.hit) begin
            $display("%0t: hit mismatch, expected %0b, got %0b", $time, exp_r.hit, got_r.hit);
            err_count++;
          end
          if (got_r.frame !== exp_r.frame) begin
            $display("%0t: found_frame mismatch, expected %0d, got %0d",
                     $time, exp_r.frame, got_r.frame);
            err_count++;
          end
          if (got_r.line !== exp_r.line) begin
            $display("%0t: physical_line mismatch, expected %0d, got %0d",
                     $time, exp_r.line, got_r.line);
            err_count++;
          end
          if (out_tdata[31:26] !== 6'd0) begin
            $display("%0t: tdata padding mismatch, expected 0, got %0h",
                     $time, out_tdata[31:26]);
            err_count++;
          end
        end
      end
    end
    pending <= result_expect_q.size();
  end

endmodule

FILE: test/tb_inverted_page_table_translate_unit.sv
// Testbench top for the inverted page table translate unit: clock, reset, request and
// config stimulus with random idling, watchdog and verdict. Depends on ipt_pkg,
// ipt_translate_checker and the unit itself.
`timescale 1ns / 100ps

module tb_inverted_page_table_translate_unit;

  localparam int FRAMES         = 256;
  localparam int WATCHDOG_LIMIT = 5000;   // idle cycles
  localparam int PHASE_ITEMS    = 97;     // random requests per lines_per_frame setting
  localparam int QUIET_ITEMS    = 40;     // tail of the run with no idling

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = ipt_pkg::LPF_RESET;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic        in_tuser = ipt_pkg::FUNC_WRITE;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tuser;
  logic [31:0] out_tdata;

  int          errors;
  int          pending;

  // stimulus knobs
  bit          quiet = 1'b0;        // no idling on either side
  int unsigned idle_pct = 20;       // chance of an idle burst per request / per cycle
  int unsigned rdy_hold = 0;
  int unsigned stall_cycles = 0;
  logic [10:0] lpf_cur = ipt_pkg::LPF_RESET;

  // shadow of what was written, used only to aim translations at live entries
  logic [15:0] wr_pid  [FRAMES];
  logic [15:0] wr_page [FRAMES];

  always #5 clk = ~clk;

  inverted_page_table_translate_unit #(.FRAMES(FRAMES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  ipt_translate_checker #(.FRAMES(FRAMES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  // Result side backpressure: random stall bursts, off in the quiet tail.
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (rdy_hold != 0) begin
      rdy_hold   <= rdy_hold - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      rdy_hold   <= $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: too long without any request or result moving means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One request, held until taken. in_tvalid stays high into the next request
  // unless an idle burst is drawn, so it gets a single assignment per step.
  task automatic send_request(input logic func, input logic [7:0] frame,
                              input logic [15:0] pid, input logic [15:0] page,
                              input logic [23:0] addr);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {addr, page, pid, frame};
    if (func == ipt_pkg::FUNC_WRITE) begin
      wr_pid[frame]  = pid;
      wr_page[frame] = page;
    end
    do @(posedge clk); while (!in_tready);
  endtask

  // Drain everything in flight, then write lines_per_frame while the unit is idle.
  task automatic set_lines_per_frame(input logic [10:0] value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lpf_cur   = value;
  endtask

  // Mostly well-formed traffic: writes, mostly with pids from a small pool and small pages,
  // mixed with translations, most aimed at live entries so scan and divide get exercised.
  task automatic issue_random_request();
    logic [7:0]  frame;
    logic [15:0] pid;
    logic [15:0] page;
    logic [23:0] addr;
    int unsigned divisor;
    int unsigned target;
    int unsigned pick;
    frame = 8'($urandom_range(0, 255));
    page  = 16'($urandom_range(0, 65535));
    addr  = 24'($urandom_range(0, 24'hFFFFFF));
    case ($urandom_range(0, 3))
      0:       pid = 16'h0000;
      1:       pid = 16'hFFFF;
      2:       pid = 16'($urandom_range(1, 7));
      default: pid = 16'($urandom_range(0, 65535));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if ($urandom_range(0, 9) < 6) page = 16'($urandom_range(0, 31));
      send_request(ipt_pkg::FUNC_WRITE, frame, pid, page, addr);
    end else if (pick < 80) begin
      // aim at a live entry; occasionally flip one pid bit to force a near miss
      divisor = (lpf_cur == 0) ? 1 : lpf_cur;
      target  = $urandom_range(0, FRAMES - 1);
      pid     = wr_pid[target];
      if ($urandom_range(0, 9) == 0) pid[4'($urandom_range(0, 15))] ^= 1'b1;
      addr    = 24'(wr_page[target] * divisor + $urandom_range(0, divisor - 1));
      send_request(ipt_pkg::FUNC_XLATE, frame, pid, page, addr);
    end else begin
      send_request(ipt_pkg::FUNC_XLATE, frame, pid, page, addr);
    end
  endtask

  initial begin : stimulus
    logic [10:0] lpf_plan [6];
    for (int i = 0; i < FRAMES; i++) begin
      wr_pid[i]  = '0;
      wr_page[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset value of lines_per_frame (16) first.
    // Zero reset: pid 0 page 0 hits frame 0.
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h0000, 16'h0000, 24'd0);
    send_request(ipt_pkg::FUNC_XLATE, 8'hFF, 16'h0000, 16'hFFFF, 24'd15);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h0000, 16'h0000, 24'd16);     // page 1, miss
    send_request(ipt_pkg::FUNC_XLATE, 8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF); // page too large
    send_request(ipt_pkg::FUNC_WRITE, 8'h00, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_request(ipt_pkg::FUNC_WRITE, 8'hFF, 16'h1234, 16'h0005, 24'h000000);
    send_request(ipt_pkg::FUNC_WRITE, 8'h01, 16'h0007, 16'h0009, 24'h5A5A5A);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h0000, 16'h0000, 24'd0);      // lowest 0/0 left
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'hFFFF, 16'h0000, 24'h0FFFFF); // top page
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h1234, 16'h0000, 24'd87);     // last frame
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h0007, 16'h0000, 24'd144);

    // lines_per_frame 0 behaves as 1
    set_lines_per_frame(11'd0);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h1234, 16'h0000, 24'd5);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'hFFFF, 16'h0000, 24'h00FFFF);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h0000, 16'h0000, 24'hFFFFFF); // page too large

    // physical line wraps to 18 bits
    set_lines_per_frame(11'd2047);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h1234, 16'h0000, 24'd12281);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'hFFFF, 16'h0000, 24'hFFFFFF);

    set_lines_per_frame(11'd1024);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h1234, 16'h0000, 24'd6143);   // max line
    send_request(ipt_pkg::FUNC_WRITE, 8'hFF, 16'h0000, 16'h0000, 24'h000000);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h0000, 16'h0000, 24'd1023);
    send_request(ipt_pkg::FUNC_WRITE, 8'h02, 16'hAAAA, 16'h5555, 24'hAAAAAA);
    send_request(ipt_pkg::FUNC_XLATE, 8'h00, 16'h0000, 16'h0000, 24'd0);      // next 0/0 frame

    // Random part: one phase per setting, extremes included, idling level varies.
    lpf_plan[0] = 11'd1;
    lpf_plan[1] = 11'd2047;
    lpf_plan[2] = 11'd0;
    lpf_plan[3] = 11'($urandom_range(2, 1023));
    lpf_plan[4] = 11'($urandom_range(1, 2047));
    lpf_plan[5] = ipt_pkg::LPF_RESET;
    for (int p = 0; p < 6; p++) begin
      set_lines_per_frame(lpf_plan[p]);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n >= PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        issue_random_request();
      end
    end

    // Drain, then allow one worst-case translation of slack before the verdict.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (FRAMES + 40) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hdl/ipt_pkg.sv
hdl/ipt_ram.sv
hdl/ipt_div.sv
hdl/inverted_page_table_translate_unit.sv
test/ipt_translate_checker.sv
test/tb_inverted_page_table_translate_unit.sv
